FILE: hdl/i2c_master_transfer_sequencer_defines.svh
// ---------------------------------------------------------------------------
// I2C master transfer sequencer: assertion macros
// Shared property wrappers; every check samples on clk and is off in reset.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/i2cms_pkg.sv
// ---------------------------------------------------------------------------
// i2cms_pkg
// Types and codes of the I2C master transfer sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

  typedef enum logic [1:0] {
    REQ_START_WR = 2'd0,
    REQ_START_RD = 2'd1,
    REQ_EVENT    = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SB_SENT   = 3'd1,
    PH_ADDR_SENT = 3'd2,
    PH_BUSY      = 3'd3,
    PH_DONE      = 3'd4
  } phase_t;

  // ACK / POS / buffer interrupt control codes
  localparam logic [1:0] CTL_KEEP = 2'd0;
  localparam logic [1:0] CTL_ON   = 2'd1;
  localparam logic [1:0] CTL_OFF  = 2'd2;

  localparam logic [1:0] CMPL_NONE  = 2'd0;
  localparam logic [1:0] CMPL_DONE  = 2'd1;
  localparam logic [1:0] CMPL_NACK  = 2'd2;

  localparam int unsigned LenW = 16;

  // register index of the slave address byte
  localparam logic REG_SLAVE_ADDR = 1'b0;

  typedef struct packed {
    logic       dr_write_valid;
    logic [7:0] dr_write_byte;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack_control;
    logic [1:0] pos_control;
    logic [1:0] buffer_irq_control;
    logic [1:0] rx_push_count;
    logic [7:0] rx_byte_first;
    logic [7:0] rx_byte_second;
    logic       tx_byte_taken;
    logic [1:0] completion;
  } result_t;

endpackage

FILE: hdl/i2c_master_transfer_sequencer.sv
// ---------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Turns start requests and controller status events into register actions
// for one I2C master write or read transfer.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_*      in   in_valid/in_ready  request or status event
//  out_*     out  out_valid/out_ready one action item per input item
//  cfg (APB) in   psel/penable       slave_write_address at 0x0
//
//  One item per cycle while in_ready is high; the sequencer state updates
//  at acceptance and the result is in the output register the cycle after.
//  in_ready drops only while a result waits and out_ready is low.
//  Synchronous active-low reset: phase idle, counts zero, address zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_read_length,
  input  logic        in_flag_start_sent,
  input  logic        in_flag_addr_done,
  input  logic        in_flag_byte_finished,
  input  logic        in_flag_tx_empty,
  input  logic        in_flag_rx_full,
  input  logic        in_flag_nack,
  input  logic [7:0]  in_data_first,
  input  logic [7:0]  in_data_second,
  input  logic        in_tx_available,
  input  logic [7:0]  in_tx_next_byte,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_dr_write_valid,
  output logic [7:0]  out_dr_write_byte,
  output logic        out_gen_start,
  output logic        out_gen_stop,
  output logic [1:0]  out_ack_control,
  output logic [1:0]  out_pos_control,
  output logic [1:0]  out_buffer_irq_control,
  output logic [1:0]  out_rx_push_count,
  output logic [7:0]  out_rx_byte_first,
  output logic [7:0]  out_rx_byte_second,
  output logic        out_tx_byte_taken,
  output logic [1:0]  out_completion
);
  import i2cms_pkg::*;
  `include "i2c_master_transfer_sequencer_defines.svh"

  logic [7:0]      slave_addr_r;
  phase_t          phase_r, phase_nxt;
  logic            reading_r, reading_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r;
  result_t         res_r, res_nxt;

  logic            in_fire;
  logic            cfg_wr;
  logic            ev_active;
  logic [LenW:0]   remain_diff;
  logic [LenW-1:0] remain;
  logic            size_one, size_two, size_big;
  logic            rem_gt3, rem_eq3, rem_eq2;
  req_t            req;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SLAVE_ADDR) ? {24'd0, slave_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd0;
    end else if (cfg_wr && paddr[2] == REG_SLAVE_ADDR) begin
      slave_addr_r <= pwdata[7:0];
    end
  end

  // ---------------- decode ----------------
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign req       = req_t'(in_req_type);
  assign ev_active = (req == REQ_EVENT) && (phase_r != PH_IDLE) && (phase_r != PH_DONE);

  // bytes still to come; zero once the count has passed the length
  assign remain_diff = {1'b0, len_r} - {1'b0, cnt_r};
  assign remain      = remain_diff[LenW] ? '0 : remain_diff[LenW-1:0];
  assign size_one    = (len_r == LenW'(1));
  assign size_two    = (len_r == LenW'(2));
  assign size_big    = (len_r > LenW'(2));
  assign rem_gt3     = (remain > LenW'(3));
  assign rem_eq3     = (remain == LenW'(3));
  assign rem_eq2     = (remain == LenW'(2));

  // ---------------- next state ----------------
  always_comb begin
    phase_nxt   = phase_r;
    reading_nxt = reading_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    case (req)
      REQ_START_WR, REQ_START_RD: begin
        phase_nxt   = PH_SB_SENT;
        reading_nxt = (req == REQ_START_RD);
        if (req == REQ_START_RD) begin
          len_nxt = in_read_length;
          cnt_nxt = '0;
        end
      end
      REQ_EVENT: begin
        if (ev_active) begin
          if (in_flag_nack) begin
            phase_nxt = PH_DONE;
          end else if (in_flag_start_sent) begin
            if (phase_r == PH_SB_SENT) phase_nxt = PH_ADDR_SENT;
          end else if (reading_r) begin
            if (in_flag_addr_done) begin
              phase_nxt = PH_BUSY;
            end else if (in_flag_byte_finished) begin
              if (size_two || (size_big && rem_eq2)) begin
                phase_nxt = PH_DONE;
              end else if (size_big && rem_eq3) begin
                cnt_nxt = cnt_r + LenW'(1);
              end
            end else if (in_flag_rx_full) begin
              if (size_one) begin
                phase_nxt = PH_DONE;
              end else if (size_big && rem_gt3) begin
                cnt_nxt = cnt_r + LenW'(1);
              end
            end
          end else begin
            if (in_flag_byte_finished) begin
              phase_nxt = PH_DONE;
            end else if (in_flag_tx_empty && in_tx_available) begin
              phase_nxt = PH_BUSY;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- result ----------------
  always_comb begin
    res_nxt = '0;
    case (req)
      REQ_START_WR, REQ_START_RD: begin
        res_nxt.gen_start = 1'b1;
        if (req == REQ_START_RD) res_nxt.ack_control = CTL_ON;
      end
      REQ_EVENT: begin
        if (ev_active) begin
          if (in_flag_nack) begin
            res_nxt.gen_stop   = 1'b1;
            res_nxt.completion = CMPL_NACK;
          end else if (in_flag_start_sent) begin
            if (phase_r == PH_SB_SENT) begin
              res_nxt.dr_write_valid = 1'b1;
              res_nxt.dr_write_byte  = slave_addr_r + {7'd0, reading_r};
            end
          end else if (reading_r) begin
            if (in_flag_addr_done) begin
              if (size_one) begin
                res_nxt.ack_control = CTL_OFF;
                res_nxt.gen_stop    = 1'b1;
              end else if (size_two) begin
                res_nxt.ack_control = CTL_OFF;
                res_nxt.pos_control = CTL_ON;
              end
              res_nxt.buffer_irq_control = CTL_ON;
            end else if (in_flag_byte_finished) begin
              if (size_two || (size_big && rem_eq2)) begin
                // last two bytes sit in DR and shift register
                res_nxt.gen_stop       = 1'b1;
                res_nxt.rx_push_count  = 2'd2;
                res_nxt.rx_byte_first  = in_data_first;
                res_nxt.rx_byte_second = in_data_second;
                res_nxt.ack_control    = CTL_ON;
                res_nxt.pos_control    = size_two ? CTL_OFF : CTL_KEEP;
                res_nxt.completion     = CMPL_DONE;
              end else if (size_big && rem_eq3) begin
                res_nxt.ack_control   = CTL_OFF;
                res_nxt.rx_push_count = 2'd1;
                res_nxt.rx_byte_first = in_data_first;
              end
            end else if (in_flag_rx_full) begin
              if (size_one) begin
                res_nxt.rx_push_count = 2'd1;
                res_nxt.rx_byte_first = in_data_first;
                res_nxt.ack_control   = CTL_ON;
                res_nxt.completion    = CMPL_DONE;
              end else if (size_big && rem_gt3) begin
                res_nxt.rx_push_count = 2'd1;
                res_nxt.rx_byte_first = in_data_first;
              end
            end
          end else begin
            res_nxt.buffer_irq_control = CTL_ON;
            if (in_flag_byte_finished) begin
              res_nxt.gen_stop           = 1'b1;
              res_nxt.buffer_irq_control = CTL_OFF;
              res_nxt.completion         = CMPL_DONE;
            end else if (in_flag_tx_empty) begin
              if (in_tx_available) begin
                res_nxt.dr_write_valid = 1'b1;
                res_nxt.dr_write_byte  = in_tx_next_byte;
                res_nxt.tx_byte_taken  = 1'b1;
              end else begin
                res_nxt.buffer_irq_control = CTL_OFF;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      reading_r   <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        reading_r   <= reading_nxt;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_dr_write_valid     = res_r.dr_write_valid;
  assign out_dr_write_byte      = res_r.dr_write_byte;
  assign out_gen_start          = res_r.gen_start;
  assign out_gen_stop           = res_r.gen_stop;
  assign out_ack_control        = res_r.ack_control;
  assign out_pos_control        = res_r.pos_control;
  assign out_buffer_irq_control = res_r.buffer_irq_control;
  assign out_rx_push_count      = res_r.rx_push_count;
  assign out_rx_byte_first      = res_r.rx_byte_first;
  assign out_rx_byte_second     = res_r.rx_byte_second;
  assign out_tx_byte_taken      = res_r.tx_byte_taken;
  assign out_completion         = res_r.completion;

  // ---------------- assertions ----------------
  `I2CMS_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ready,
    "input stalled with empty output register")
  `I2CMS_ASSERT_NEXT(a_start_phase, in_fire && (req == REQ_START_WR || req == REQ_START_RD),
    phase_r == PH_SB_SENT && out_gen_start, "start request did not arm SB phase")
  `I2CMS_ASSERT_NEXT(a_nack_done, in_fire && ev_active && in_flag_nack,
    phase_r == PH_DONE && out_completion == CMPL_NACK, "NACK did not abort transfer")
  `I2CMS_ASSERT_NOW(a_push_bytes, out_valid_r && out_rx_push_count == 2'd0,
    out_rx_byte_first == 8'd0 && out_rx_byte_second == 8'd0,
    "rx bytes driven without a push")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master transfer sequencer. Requests and
// status events go in over a valid/ready channel, a cycle model in the bench
// predicts the action item of each one, and a monitor compares every action
// item that leaves the block. The slave address is set over the APB port at
// idle points and read back.
// ---------------------------------------------------------------------------

module testbench;
  import i2cms_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [2:0] SLAVE_ADDR_OFS = {REG_SLAVE_ADDR, 2'b00};

  typedef struct {
    req_t        req;
    logic [15:0] read_len;
    logic        sb;
    logic        addr_ack;
    logic        btf;
    logic        txe;
    logic        rxne;
    logic        nack;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic        tx_av;
    logic [7:0]  tx_byte;
  } status_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_NONE;
  logic [15:0] in_read_length = '0;
  logic        in_flag_start_sent = 1'b0;
  logic        in_flag_addr_done = 1'b0;
  logic        in_flag_byte_finished = 1'b0;
  logic        in_flag_tx_empty = 1'b0;
  logic        in_flag_rx_full = 1'b0;
  logic        in_flag_nack = 1'b0;
  logic [7:0]  in_data_first = '0;
  logic [7:0]  in_data_second = '0;
  logic        in_tx_available = 1'b0;
  logic [7:0]  in_tx_next_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_dr_write_valid;
  logic [7:0]  out_dr_write_byte;
  logic        out_gen_start;
  logic        out_gen_stop;
  logic [1:0]  out_ack_control;
  logic [1:0]  out_pos_control;
  logic [1:0]  out_buffer_irq_control;
  logic [1:0]  out_rx_push_count;
  logic [7:0]  out_rx_byte_first;
  logic [7:0]  out_rx_byte_second;
  logic        out_tx_byte_taken;
  logic [1:0]  out_completion;

  // sequencer model state
  phase_t      seq_phase = PH_IDLE;
  logic        seq_reading = 1'b0;
  logic [15:0] seq_len = '0;
  logic [15:0] seq_rcvd = '0;
  logic        seq_nack = 1'b0;
  logic [7:0]  slave_addr_byte = '0;

  result_t     expected_actions[$];
  int          n_err = 0;
  int          idle_cycles = 0;
  logic        tx_idle_en = 1'b1;
  logic        rx_stall_en = 1'b1;
  logic        rx_hold_req = 1'b0;

  // random transfer generator state
  int          gen_wr_left = 0;
  int          gen_evts = 0;
  int          gen_cap = 0;

  i2c_master_transfer_sequencer i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_req_type            (in_req_type),
    .in_read_length         (in_read_length),
    .in_flag_start_sent     (in_flag_start_sent),
    .in_flag_addr_done      (in_flag_addr_done),
    .in_flag_byte_finished  (in_flag_byte_finished),
    .in_flag_tx_empty       (in_flag_tx_empty),
    .in_flag_rx_full        (in_flag_rx_full),
    .in_flag_nack           (in_flag_nack),
    .in_data_first          (in_data_first),
    .in_data_second         (in_data_second),
    .in_tx_available        (in_tx_available),
    .in_tx_next_byte        (in_tx_next_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_dr_write_valid     (out_dr_write_valid),
    .out_dr_write_byte      (out_dr_write_byte),
    .out_gen_start          (out_gen_start),
    .out_gen_stop           (out_gen_stop),
    .out_ack_control        (out_ack_control),
    .out_pos_control        (out_pos_control),
    .out_buffer_irq_control (out_buffer_irq_control),
    .out_rx_push_count      (out_rx_push_count),
    .out_rx_byte_first      (out_rx_byte_first),
    .out_rx_byte_second     (out_rx_byte_second),
    .out_tx_byte_taken      (out_tx_byte_taken),
    .out_completion         (out_completion)
  );

  always #CLK_HALF clk = ~clk;

  // -------------------------------------------------------------------------
  // Model: action item for one accepted item, state updated in place
  // -------------------------------------------------------------------------
  function automatic result_t sequencer_predict(input status_item_t it);
    result_t     r;
    int unsigned size;
    int unsigned cnt;
    int unsigned remain;
    r = '0;
    size = 32'(seq_len);
    cnt = 32'(seq_rcvd);
    remain = (cnt <= size) ? size - cnt : 0;
    if (it.req == REQ_START_WR || it.req == REQ_START_RD) begin
      r.gen_start = 1'b1;
      seq_reading = (it.req == REQ_START_RD);
      seq_phase = PH_SB_SENT;
      seq_nack = 1'b0;
      if (it.req == REQ_START_RD) begin
        r.ack_control = CTL_ON;
        seq_len = it.read_len;
        seq_rcvd = '0;
      end
    end else if (it.req == REQ_EVENT && seq_phase != PH_IDLE && seq_phase != PH_DONE) begin
      if (it.nack) begin
        r.gen_stop = 1'b1;
        r.completion = CMPL_NACK;
        seq_nack = 1'b1;
        seq_phase = PH_DONE;
      end else if (it.sb) begin
        // SB only counts right after START; NACK wins over it, other flags are not looked at
        if (seq_phase == PH_SB_SENT) begin
          r.dr_write_valid = 1'b1;
          r.dr_write_byte = slave_addr_byte + {7'd0, seq_reading};
          seq_phase = PH_ADDR_SENT;
        end
      end else if (seq_reading) begin
        if (it.addr_ack) begin
          if (size == 1) begin
            r.ack_control = CTL_OFF;
            r.gen_stop = 1'b1;
          end else if (size == 2) begin
            r.ack_control = CTL_OFF;
            r.pos_control = CTL_ON;
          end
          seq_phase = PH_BUSY;
          r.buffer_irq_control = CTL_ON;
        end else if (it.btf) begin
          if (size == 2) begin
            r.gen_stop = 1'b1;
            r.rx_push_count = 2'd2;
            r.rx_byte_first = it.data1;
            r.rx_byte_second = it.data2;
            r.pos_control = CTL_OFF;
            r.ack_control = CTL_ON;
            r.completion = CMPL_DONE;
            seq_phase = PH_DONE;
          end else if (size > 2 && remain == 3) begin
            r.ack_control = CTL_OFF;
            r.rx_push_count = 2'd1;
            r.rx_byte_first = it.data1;
            seq_rcvd = seq_rcvd + 16'd1;
          end else if (size > 2 && remain == 2) begin
            r.gen_stop = 1'b1;
            r.ack_control = CTL_ON;
            r.rx_push_count = 2'd2;
            r.rx_byte_first = it.data1;
            r.rx_byte_second = it.data2;
            r.completion = CMPL_DONE;
            seq_phase = PH_DONE;
          end
        end else if (it.rxne) begin
          if (size == 1) begin
            r.rx_push_count = 2'd1;
            r.rx_byte_first = it.data1;
            r.ack_control = CTL_ON;
            r.completion = CMPL_DONE;
            seq_phase = PH_DONE;
          end else if (size > 2 && remain > 3) begin
            r.rx_push_count = 2'd1;
            r.rx_byte_first = it.data1;
            seq_rcvd = seq_rcvd + 16'd1;
          end
        end
      end else begin
        r.buffer_irq_control = CTL_ON;
        if (it.btf) begin
          r.gen_stop = 1'b1;
          r.buffer_irq_control = CTL_OFF;
          r.completion = CMPL_DONE;
          seq_phase = PH_DONE;
        end else if (it.txe) begin
          if (it.tx_av) begin
            seq_phase = PH_BUSY;
            r.dr_write_valid = 1'b1;
            r.dr_write_byte = it.tx_byte;
            r.tx_byte_taken = 1'b1;
          end else begin
            r.buffer_irq_control = CTL_OFF;
          end
        end
      end
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Item builders
  // -------------------------------------------------------------------------
  function automatic status_item_t random_item();
    status_item_t it;
    it.req = req_t'($urandom_range(0, 3));
    it.read_len = 16'($urandom_range(0, 16'hFFFF));
    it.sb = 1'($urandom_range(0, 1));
    it.addr_ack = 1'($urandom_range(0, 1));
    it.btf = 1'($urandom_range(0, 1));
    it.txe = 1'($urandom_range(0, 1));
    it.rxne = 1'($urandom_range(0, 1));
    it.nack = 1'($urandom_range(0, 1));
    it.data1 = 8'($urandom_range(0, 255));
    it.data2 = 8'($urandom_range(0, 255));
    it.tx_av = 1'($urandom_range(0, 1));
    it.tx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic status_item_t status_ev(input logic sb, addr_ack, btf, txe, rxne,
                                             nack);
    status_item_t it;
    it = random_item();
    it.req = REQ_EVENT;
    it.sb = sb;
    it.addr_ack = addr_ack;
    it.btf = btf;
    it.txe = txe;
    it.rxne = rxne;
    it.nack = nack;
    it.tx_av = 1'b1;
    return it;
  endfunction

  function automatic status_item_t start_req(input req_t rq, input logic [15:0] len);
    status_item_t it;
    it = random_item();
    it.req = rq;
    it.read_len = len;
    return it;
  endfunction

  // Mostly well-formed transfers driven off the model state, some noise
  function automatic status_item_t next_transfer_item();
    status_item_t it;
    int unsigned  remain;
    int unsigned  pick;
    it = status_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    if ($urandom_range(0, 9) == 0) begin
      it = random_item();
    end else if (seq_phase == PH_IDLE || seq_phase == PH_DONE || gen_evts >= gen_cap) begin
      gen_evts = 0;
      if ($urandom_range(0, 1) == 0) begin
        it = start_req(REQ_START_WR, 16'($urandom_range(0, 16'hFFFF)));
        gen_wr_left = $urandom_range(0, 6);
        gen_cap = 2 * gen_wr_left + 12;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 6)
          it = start_req(REQ_START_RD, 16'($urandom_range(1, 6)));
        else if (pick <= 8)
          it = start_req(REQ_START_RD, 16'($urandom_range(7, 20)));
        else if ($urandom_range(0, 2) == 0)
          it = start_req(REQ_START_RD, 16'h0000);
        else if ($urandom_range(0, 1) == 0)
          it = start_req(REQ_START_RD, 16'hFFFF);
        else
          it = start_req(REQ_START_RD, 16'($urandom_range(0, 16'hFFFF)));
        gen_cap = ((it.read_len > 20) ? 20 : it.read_len) + 12;
      end
    end else begin
      gen_evts++;
      remain = (seq_rcvd <= seq_len) ? seq_len - seq_rcvd : 0;
      if (seq_phase == PH_SB_SENT) begin
        it.sb = 1'b1;
      end else if (!seq_reading) begin
        if (seq_phase == PH_ADDR_SENT && $urandom_range(0, 1) == 0) begin
          it.addr_ack = 1'b1;
        end else if (gen_wr_left > 0) begin
          it.txe = 1'b1;
          it.tx_av = ($urandom_range(0, 5) != 0);
          if (it.tx_av)
            gen_wr_left--;
        end else begin
          it.btf = 1'b1;
          it.txe = 1'($urandom_range(0, 1));
        end
      end else if (seq_phase == PH_ADDR_SENT) begin
        it.addr_ack = 1'b1;
      end else if (seq_len == 2 || (seq_len > 2 && remain <= 3)) begin
        it.btf = 1'b1;
        it.rxne = 1'($urandom_range(0, 1));
      end else begin
        it.rxne = 1'b1;
      end
      if ($urandom_range(0, 24) == 0)
        it.nack = 1'b1;
    end
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  task automatic offer_item(input status_item_t it);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_read_length <= it.read_len;
    in_flag_start_sent <= it.sb;
    in_flag_addr_done <= it.addr_ack;
    in_flag_byte_finished <= it.btf;
    in_flag_tx_empty <= it.txe;
    in_flag_rx_full <= it.rxne;
    in_flag_nack <= it.nack;
    in_data_first <= it.data1;
    in_data_second <= it.data2;
    in_tx_available <= it.tx_av;
    in_tx_next_byte <= it.tx_byte;
    do @(posedge clk); while (!in_ready);
    expected_actions.push_back(sequencer_predict(it));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Block must be idle: write the slave address, then read it back
  task automatic cfg_write(input logic [7:0] val);
    wait_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLAVE_ADDR_OFS;
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    slave_addr_byte = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, val}) begin
      n_err++;
      $display("%0t: slave address readback: expected %0h, actual %0h", $time, val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off on request
  // -------------------------------------------------------------------------
  initial begin : out_ready_ctl
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result check
  // -------------------------------------------------------------------------
  task automatic cmp_field(input string nm, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, nm, want, got);
    end
  endtask

  always @(posedge clk) begin : action_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        n_err++;
        $display("%0t: result item with none expected: expected none, actual completion %0d",
                 $time, out_completion);
      end else begin
        want = expected_actions.pop_front();
        cmp_field("dr_write_valid", 8'(want.dr_write_valid), 8'(out_dr_write_valid));
        cmp_field("dr_write_byte", want.dr_write_byte, out_dr_write_byte);
        cmp_field("gen_start", 8'(want.gen_start), 8'(out_gen_start));
        cmp_field("gen_stop", 8'(want.gen_stop), 8'(out_gen_stop));
        cmp_field("ack_control", 8'(want.ack_control), 8'(out_ack_control));
        cmp_field("pos_control", 8'(want.pos_control), 8'(out_pos_control));
        cmp_field("buffer_irq_control", 8'(want.buffer_irq_control),
                  8'(out_buffer_irq_control));
        cmp_field("rx_push_count", 8'(want.rx_push_count), 8'(out_rx_push_count));
        cmp_field("rx_byte_first", want.rx_byte_first, out_rx_byte_first);
        cmp_field("rx_byte_second", want.rx_byte_second, out_rx_byte_second);
        cmp_field("tx_byte_taken", 8'(want.tx_byte_taken), 8'(out_tx_byte_taken));
        cmp_field("completion", 8'(want.completion), 8'(out_completion));
      end
    end
  end

  // Watchdog: cycles with no item moving on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_idle_and_unknown();
    cfg_write(8'h00);
    offer_item(status_ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    offer_item(start_req(REQ_NONE, 16'hFFFF));
  endtask

  task automatic test_write_transfer();
    status_item_t it;
    cfg_write(8'h5A);
    offer_item(start_req(REQ_START_WR, 16'h0000));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    it = status_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    it.tx_byte = 8'hFF;
    offer_item(it);
    it = status_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    it.tx_byte = 8'h00;
    offer_item(it);
    // TxE with an empty supply
    it.tx_av = 1'b0;
    offer_item(it);
    offer_item(status_ev(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_read_one_two();
    status_item_t it;
    cfg_write(8'hFF);   // read address wraps to zero
    offer_item(start_req(REQ_START_RD, 16'd1));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    it = status_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    it.data1 = 8'hFF;
    offer_item(it);
    offer_item(start_req(REQ_START_RD, 16'd2));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    // late SB masks the BTF that comes with it
    offer_item(status_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    it = status_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    it.data1 = 8'h00;
    it.data2 = 8'hFF;
    offer_item(it);
  endtask

  task automatic test_read_three();
    cfg_write(8'hFE);
    offer_item(start_req(REQ_START_RD, 16'd3));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    offer_item(status_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic test_nack_and_restart();
    offer_item(start_req(REQ_START_RD, 16'd0));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    // restart on top of the stuck zero-length read
    offer_item(start_req(REQ_START_RD, 16'hFFFF));
    offer_item(status_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(status_ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    offer_item(status_ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_random_transfers();
    logic [7:0] addr_set[4];
    addr_set[0] = 8'h00;
    addr_set[1] = 8'hFE;
    addr_set[2] = 8'($urandom_range(0, 254));
    addr_set[3] = 8'($urandom_range(0, 254));
    for (int p = 0; p < 4; p++) begin
      cfg_write(addr_set[p]);
      repeat (85) offer_item(next_transfer_item());
    end
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    repeat (40) offer_item(next_transfer_item());
  endtask

  task automatic test_final_stretch();
    tx_idle_en = 1'b0;
    rx_stall_en = 1'b0;
    repeat (40) offer_item(next_transfer_item());
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_unknown();
    test_write_transfer();
    test_read_one_two();
    test_read_three();
    test_nack_and_restart();
    test_random_transfers();
    test_backpressure();
    test_final_stretch();
    wait_drain();
    if (n_err == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
